FILE: design/sid_pkg.sv
// shared types and constants for the set intersection block
package sid_pkg;

  localparam int DEPTH         = 32;
  localparam int ELEMENT_WIDTH = 64;

  // transaction kinds on the input channel
  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_PROBE = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] element;
  } in_t;

  typedef struct packed {
    logic [63:0] common_element;
    logic        found;
    logic        reference_overflow;
  } out_t;

  // token that walks down the chain of cells, one cell per cycle
  typedef struct packed {
    logic                     vld;
    logic                     load;
    logic [ELEMENT_WIDTH-1:0] word;
    logic                     hit;
    logic                     taken;
  } tok_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic clear;
    logic commit;
    logic hit;
  } ctl_t;

endpackage

FILE: design/sid_cell.sv
// one store entry of the chain: holds a value and its flags, passes the token on
module sid_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  sid_pkg::tok_t tok_in,
  input  sid_pkg::ctl_t ctl,
  output sid_pkg::tok_t tok_out
);
  import sid_pkg::*;

  logic [ELEMENT_WIDTH-1:0] value_r, value_nxt;
  logic                     valid_r, valid_nxt;
  logic                     reported_r, reported_nxt;
  logic                     match_r, match_nxt;
  tok_t                     tok_r, tok_nxt;
  logic                     eq;

  always_comb begin
    eq           = valid_r && (value_r == tok_in.word);
    value_nxt    = value_r;
    valid_nxt    = valid_r;
    reported_nxt = reported_r;
    match_nxt    = match_r;
    tok_nxt      = tok_in;
    if (ctl.clear) begin
      valid_nxt    = 1'b0;
      reported_nxt = 1'b0;
    end else if (ctl.commit) begin
      // when the probe hit, mark every entry that matched the probe just finished
      if (ctl.hit && match_r) begin
        reported_nxt = 1'b1;
      end
    end else if (tok_in.vld) begin
      if (tok_in.load) begin
        // first empty cell takes the load
        if (!tok_in.taken && !valid_r) begin
          value_nxt     = tok_in.word;
          valid_nxt     = 1'b1;
          reported_nxt  = 1'b0;
          tok_nxt.taken = 1'b1;
        end
      end else begin
        match_nxt = eq;
        if (eq && !reported_r) begin
          tok_nxt.hit = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      reported_r <= 1'b0;
      match_r    <= 1'b0;
      tok_r      <= '0;
    end else begin
      valid_r    <= valid_nxt;
      reported_r <= reported_nxt;
      match_r    <= match_nxt;
      tok_r      <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign tok_out = tok_r;

endmodule

FILE: design/set_intersection_dedup.sv
// top level: set intersection with duplicate removal over a chain of store cells
//
// usage
//   input channel (in_valid / in_stall / in_data) carries load, probe and clear
//   transactions; result channel (out_valid / out_stall / out_data) carries one
//   transaction per probe, none for load, clear or the unused kind code
//   a load fills the next empty store entry; loads past DEPTH entries are
//   dropped and set the sticky reference_overflow flag
//   a probe reports found when it equals a stored entry not reported yet, and
//   then marks every equal entry as reported
//   a probe token is registered in each of the DEPTH cells in turn; the last
//   cell feeds the output register directly, which then raises out_valid
//   clear and the unused kind leave the sequencer idle
//   one transaction at a time: a load or probe holds off the next transaction
//   in_stall is high while a token walks the chain or a result waits for
//   room in the output register
//   when the receiver stalls, the finished result holds in the output register;
//   a further probe can walk the chain meanwhile and waits at its end
//   reset (rst_n low, synchronous) empties the store and clears the flag
module set_intersection_dedup (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  sid_pkg::in_t in_data,
  output logic         out_valid,
  input  logic         out_stall,
  output sid_pkg::out_t out_data
);
  import sid_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_DONE
  } state_t;

  state_t                   state_r, state_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_t                     out_r, out_nxt;
  logic                     overflow_r, overflow_nxt;
  logic [ELEMENT_WIDTH-1:0] hold_word_r, hold_word_nxt;
  logic                     hold_hit_r, hold_hit_nxt;

  tok_t                     tok_chain [DEPTH+1];
  tok_t                     last_tok;
  ctl_t                     ctl;
  logic                     in_acc;
  logic                     out_free;
  logic                     fire;
  logic [ELEMENT_WIDTH-1:0] res_word;
  logic                     res_hit;

  // handshake
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign last_tok = tok_chain[DEPTH];

  // token injected into the head of the chain
  always_comb begin
    tok_chain[0].vld   = in_acc && ((in_data.kind == KIND_LOAD) ||
                                    (in_data.kind == KIND_PROBE));
    tok_chain[0].load  = (in_data.kind == KIND_LOAD);
    tok_chain[0].word  = in_data.element[ELEMENT_WIDTH-1:0];
    tok_chain[0].hit   = 1'b0;
    tok_chain[0].taken = 1'b0;
  end

  // chain of store cells
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    sid_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tok_in  (tok_chain[gi]),
      .ctl     (ctl),
      .tok_out (tok_chain[gi+1])
    );
  end

  // probe result, straight from the chain end or from the hold registers
  always_comb begin
    if (state_r == S_DONE) begin
      res_word = hold_word_r;
      res_hit  = hold_hit_r;
    end else begin
      res_word = last_tok.word;
      res_hit  = last_tok.hit;
    end
  end

  // a result goes to the output register and the cells commit the report marks
  assign fire = ((state_r == S_SWEEP && last_tok.vld && !last_tok.load) ||
                 (state_r == S_DONE)) && out_free;

  always_comb begin
    ctl.clear  = in_acc && (in_data.kind == KIND_CLEAR);
    ctl.commit = fire;
    ctl.hit    = res_hit;
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    overflow_nxt  = overflow_r;
    hold_word_nxt = hold_word_r;
    hold_hit_nxt  = hold_hit_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_data.kind)
            KIND_LOAD, KIND_PROBE: state_nxt = S_SWEEP;
            KIND_CLEAR:            overflow_nxt = 1'b0;
            default:               state_nxt = S_IDLE;
          endcase
        end
      end
      S_SWEEP: begin
        if (last_tok.vld) begin
          if (last_tok.load) begin
            // no empty cell took the load: dropped
            if (!last_tok.taken) begin
              overflow_nxt = 1'b1;
            end
            state_nxt = S_IDLE;
          end else begin
            hold_word_nxt = last_tok.word;
            hold_hit_nxt  = last_tok.hit;
            state_nxt     = fire ? S_IDLE : S_DONE;
          end
        end
      end
      S_DONE: begin
        if (fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (fire) begin
      out_valid_nxt              = 1'b1;
      out_nxt.common_element     = 64'(res_hit ? res_word : '0);
      out_nxt.found              = res_hit;
      out_nxt.reference_overflow = overflow_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      overflow_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      overflow_r  <= overflow_nxt;
      out_r       <= out_nxt;
      hold_word_r <= hold_word_nxt;
      hold_hit_r  <= hold_hit_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // a load or probe transaction starts a sweep of the chain
  a_start_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    tok_chain[0].vld |=> (state_r == S_SWEEP))
    else $error("load or probe did not start a sweep");

  // a token only leaves the chain while the sequencer waits for it
  a_token_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    last_tok.vld |-> (state_r == S_SWEEP))
    else $error("token left the chain outside a sweep");

  // every commit of report marks comes with a result in the output register
  a_commit_output: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit |=> out_valid_r)
    else $error("commit without a result");

  // a clear drops the sticky overflow flag
  a_clear_flag: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clear |=> !overflow_r)
    else $error("overflow flag survived a clear");
`endif

endmodule
